### design/tmvd_pkg.sv
`timescale 1ns / 1ps
package tmvd_pkg;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 14;
    localparam int PIX_W     = 16;
    localparam int SUM_W     = 22;
    localparam int SQ_W      = 38;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 8;
    localparam int MT_W      = 48;
    localparam int VT_W      = 32;
    localparam int MASK_W    = 3;
    localparam int CH_N      = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;

    // result quotient width and pipeline depths
    localparam int Q_W        = 16;
    localparam int STATS_LAT  = 4;
    localparam int DIV_LAT    = Q_W + 3;
    localparam int PIPE_LAT   = STATS_LAT + DIV_LAT;
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};
    localparam logic [PIX_W-1:0] FULL16  = 16'hffff;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD,
        CMD_SUB,
        CMD_OUT,
        CMD_CLR
    } t_cmd;

    typedef enum logic [1:0] {
        MTH_PASS,
        MTH_SEL,
        MTH_MEAN,
        MTH_VAR
    } t_method;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_METHOD,
        REG_GAIN,
        REG_MEAN_THR,
        REG_VT1,
        REG_VT2,
        REG_VT3,
        REG_MASK
    } t_reg;

    // per-channel view of the configuration
    typedef struct packed {
        t_method           method;
        logic [GAIN_W-1:0] gain;
        logic [PIX_W-1:0]  tm;
        logic [VT_W-1:0]   vt;
        logic              masked;
    } t_chan_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic [PIX_W-1:0] out_1;
        logic [PIX_W-1:0] out_2;
        logic [PIX_W-1:0] out_3;
    } t_res;

endpackage

### design/tmvd_if.sv
`timescale 1ns / 1ps
interface tmvd_in_if;
    logic                        valid;
    logic                        ready;
    logic [tmvd_pkg::CMD_W-1:0]  cmd;
    logic [tmvd_pkg::IDX_W-1:0]  pixel_index;
    logic [tmvd_pkg::PIX_W-1:0]  chan_1;
    logic [tmvd_pkg::PIX_W-1:0]  chan_2;
    logic [tmvd_pkg::PIX_W-1:0]  chan_3;
    modport source (output valid, cmd, pixel_index, chan_1, chan_2, chan_3, input ready);
    modport sink   (input valid, cmd, pixel_index, chan_1, chan_2, chan_3, output ready);
endinterface

interface tmvd_out_if;
    logic                        valid;
    logic                        ready;
    logic [tmvd_pkg::IDX_W-1:0]  out_index;
    logic [tmvd_pkg::PIX_W-1:0]  out_1;
    logic [tmvd_pkg::PIX_W-1:0]  out_2;
    logic [tmvd_pkg::PIX_W-1:0]  out_3;
    modport source (output valid, out_index, out_1, out_2, out_3, input ready);
    modport sink   (input valid, out_index, out_1, out_2, out_3, output ready);
endinterface

interface tmvd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tmvd_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [tmvd_pkg::CFG_DAT_W-1:0]  data;
    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

### design/tmvd_ram.sv
`timescale 1ns / 1ps
module tmvd_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/tmvd_stats.sv
`timescale 1ns / 1ps
module tmvd_stats #(
    parameter int CNT_W = 7,
    parameter int NUM_W = 61,
    parameter int DEN_W = 38
) (
    input  logic                          i_clk,
    input  tmvd_pkg::t_chan_cfg           i_cfg,
    input  logic                          i_byp,
    input  logic [tmvd_pkg::PIX_W-1:0]    i_x,
    input  logic [tmvd_pkg::SUM_W-1:0]    i_s,
    input  logic [tmvd_pkg::SQ_W-1:0]     i_q,
    input  logic [CNT_W-1:0]              i_n,
    output logic [NUM_W-1:0]              o_num,
    output logic [DEN_W-1:0]              o_den,
    output logic                          o_byp,
    output logic [tmvd_pkg::PIX_W-1:0]    o_bval
);
    import tmvd_pkg::*;

    localparam int XN_W   = PIX_W + CNT_W;
    localparam int S2_W   = 2 * SUM_W;
    localparam int NQ_W   = SQ_W + CNT_W;
    localparam int TMN_W  = PIX_W + CNT_W;
    localparam int N2_W   = 2 * CNT_W;
    localparam int SG_W   = SUM_W + GAIN_W;
    localparam int XG_W   = PIX_W + GAIN_W;
    localparam int D_W    = (NQ_W > S2_W) ? NQ_W : S2_W;
    localparam int DEV_W  = (XN_W > SUM_W) ? XN_W : SUM_W;
    localparam int VTN2_W = VT_W + N2_W;
    localparam int DG_W   = D_W + GAIN_W;
    localparam int CV_W   = (VTN2_W > D_W) ? VTN2_W : D_W;
    localparam int CT_W   = (TMN_W > DEV_W) ? TMN_W : DEV_W;

    // B: operands
    logic [PIX_W-1:0]  r_b_x;
    logic [SUM_W-1:0]  r_b_s;
    logic [SQ_W-1:0]   r_b_q;
    logic [CNT_W-1:0]  r_b_n;
    logic              r_b_byp;
    // C: products
    logic [XN_W-1:0]   r_c_xn;
    logic [S2_W-1:0]   r_c_s2;
    logic [NQ_W-1:0]   r_c_nq;
    logic [TMN_W-1:0]  r_c_tmn;
    logic [N2_W-1:0]   r_c_n2;
    logic [SG_W-1:0]   r_c_sg;
    logic [XG_W-1:0]   r_c_xg;
    logic [SUM_W-1:0]  r_c_s;
    logic [PIX_W-1:0]  r_c_x;
    logic [CNT_W-1:0]  r_c_n;
    logic              r_c_byp;
    // D: differences
    logic [DEV_W-1:0]  r_d_dev;
    logic [D_W-1:0]    r_d_d;
    logic              r_d_lt;
    logic [VTN2_W-1:0] r_d_vtn2;
    logic [TMN_W-1:0]  r_d_tmn;
    logic [N2_W-1:0]   r_d_n2;
    logic [SG_W-1:0]   r_d_sg;
    logic [XG_W-1:0]   r_d_xg;
    logic [PIX_W-1:0]  r_d_x;
    logic [CNT_W-1:0]  r_d_n;
    logic              r_d_byp;
    // E: decision
    logic              r_e_pass;
    logic [DG_W-1:0]   r_e_dg;
    logic [SG_W-1:0]   r_e_sg;
    logic [XG_W-1:0]   r_e_xg;
    logic [N2_W-1:0]   r_e_n2;
    logic [CNT_W-1:0]  r_e_n;
    logic [PIX_W-1:0]  r_e_x;
    logic              r_e_byp;

    logic [DEV_W-1:0]  w_xn;
    logic [DEV_W-1:0]  w_se;
    logic [D_W-1:0]    w_nq;
    logic [D_W-1:0]    w_s2;
    logic [DEN_W-1:0]  w_den_mean;
    logic [DEN_W-1:0]  w_den_var;
    logic [DEN_W-1:0]  w_den_one;

    assign w_xn = DEV_W'(r_c_xn);
    assign w_se = DEV_W'(r_c_s);
    assign w_nq = D_W'(r_c_nq);
    assign w_s2 = D_W'(r_c_s2);

    always_ff @(posedge i_clk) begin
        r_b_x   <= i_x;
        r_b_s   <= i_s;
        r_b_q   <= i_q;
        r_b_n   <= i_n;
        r_b_byp <= i_byp;

        r_c_xn  <= XN_W'(r_b_x) * XN_W'(r_b_n);
        r_c_s2  <= S2_W'(r_b_s) * S2_W'(r_b_s);
        r_c_nq  <= NQ_W'(r_b_q) * NQ_W'(r_b_n);
        r_c_tmn <= TMN_W'(i_cfg.tm) * TMN_W'(r_b_n);
        r_c_n2  <= N2_W'(r_b_n) * N2_W'(r_b_n);
        r_c_sg  <= SG_W'(r_b_s) * SG_W'(i_cfg.gain);
        r_c_xg  <= XG_W'(r_b_x) * XG_W'(i_cfg.gain);
        r_c_s   <= r_b_s;
        r_c_x   <= r_b_x;
        r_c_n   <= r_b_n;
        r_c_byp <= r_b_byp;

        r_d_dev  <= (w_xn > w_se) ? (w_xn - w_se) : (w_se - w_xn);
        r_d_lt   <= w_nq < w_s2;
        r_d_d    <= (w_nq < w_s2) ? '0 : (w_nq - w_s2);
        r_d_vtn2 <= VTN2_W'(i_cfg.vt) * VTN2_W'(r_c_n2);
        r_d_tmn  <= r_c_tmn;
        r_d_n2   <= r_c_n2;
        r_d_sg   <= r_c_sg;
        r_d_xg   <= r_c_xg;
        r_d_x    <= r_c_x;
        r_d_n    <= r_c_n;
        r_d_byp  <= r_c_byp;

        r_e_pass <= (CT_W'(r_d_tmn) > CT_W'(r_d_dev))
                    && (r_d_lt || (CV_W'(r_d_vtn2) > CV_W'(r_d_d)));
        r_e_dg   <= DG_W'(r_d_d) * DG_W'(i_cfg.gain);
        r_e_sg   <= r_d_sg;
        r_e_xg   <= r_d_xg;
        r_e_n2   <= r_d_n2;
        r_e_n    <= r_d_n;
        r_e_x    <= r_d_x;
        r_e_byp  <= r_d_byp;
    end

    // n*256, n^2*256*65535, and 256
    assign w_den_mean = DEN_W'(r_e_n) << GAIN_FRAC;
    assign w_den_var  = (DEN_W'(r_e_n2) << (GAIN_FRAC + PIX_W))
                        - (DEN_W'(r_e_n2) << GAIN_FRAC);
    assign w_den_one  = DEN_W'(1) << GAIN_FRAC;

    always_comb begin
        o_num  = '0;
        o_den  = w_den_one;
        o_byp  = 1'b1;
        o_bval = r_e_x;
        if (!r_e_byp) begin
            case (i_cfg.method)
                MTH_MEAN: begin
                    o_byp = 1'b0;
                    o_num = NUM_W'(r_e_sg);
                    o_den = w_den_mean;
                end
                MTH_VAR: begin
                    o_byp = 1'b0;
                    o_num = NUM_W'(r_e_dg);
                    o_den = w_den_var;
                end
                MTH_SEL: begin
                    if (r_e_pass) begin
                        if (i_cfg.masked) begin
                            o_bval = FULL16;
                        end else begin
                            o_byp = 1'b0;
                            o_num = NUM_W'(r_e_sg);
                            o_den = w_den_mean;
                        end
                    end else begin
                        if (i_cfg.masked) begin
                            o_bval = '0;
                        end else begin
                            o_byp = 1'b0;
                            o_num = NUM_W'(r_e_xg);
                            o_den = w_den_one;
                        end
                    end
                end
                MTH_PASS: begin
                    o_bval = r_e_x;
                end
            endcase
        end
    end
endmodule

### design/tmvd_div.sv
`timescale 1ns / 1ps
module tmvd_div #(
    parameter int NUM_W = 61,
    parameter int DEN_W = 38
) (
    input  logic                        i_clk,
    input  logic [NUM_W-1:0]            i_num,
    input  logic [DEN_W-1:0]            i_den,
    input  logic                        i_byp,
    input  logic [tmvd_pkg::PIX_W-1:0]  i_bval,
    output logic [tmvd_pkg::PIX_W-1:0]  o_res
);
    import tmvd_pkg::*;

    // round half up: q = (2*num + den) / (2*den), saturated at 16 bits
    localparam int N_W  = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 2;
    localparam int D2_W = DEN_W + 1;
    localparam int C_W  = (N_W > D2_W + Q_W) ? N_W : (D2_W + Q_W);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic             r_byp0;
    logic [PIX_W-1:0] r_bv0;
    logic [N_W-1:0]   r_n;
    logic [D2_W-1:0]  r_d2i;
    logic             r_byp1;
    logic [PIX_W-1:0] r_bv1;

    logic [N_W-1:0]   r_rem [Q_W+1];
    logic [D2_W-1:0]  r_d2  [Q_W+1];
    logic [Q_W-1:0]   r_q   [Q_W+1];
    logic             r_sat [Q_W+1];
    logic             r_byp [Q_W+1];
    logic [PIX_W-1:0] r_bv  [Q_W+1];

    always_ff @(posedge i_clk) begin
        r_num  <= i_num;
        r_den  <= i_den;
        r_byp0 <= i_byp;
        r_bv0  <= i_bval;

        r_n    <= (N_W'(r_num) << 1) + N_W'(r_den);
        r_d2i  <= D2_W'(r_den) << 1;
        r_byp1 <= r_byp0;
        r_bv1  <= r_bv0;

        r_rem[0] <= r_n;
        r_d2[0]  <= r_d2i;
        r_q[0]   <= '0;
        r_sat[0] <= C_W'(r_n) >= (C_W'(r_d2i) << Q_W);
        r_byp[0] <= r_byp1;
        r_bv[0]  <= r_bv1;
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 1; j <= Q_W; j++) begin : g_step
        logic [C_W-1:0] w_sh;
        logic           w_ge;

        assign w_sh = C_W'(r_d2[j-1]) << (Q_W - j);
        assign w_ge = C_W'(r_rem[j-1]) >= w_sh;

        always_ff @(posedge i_clk) begin
            r_rem[j] <= w_ge ? N_W'(C_W'(r_rem[j-1]) - w_sh) : r_rem[j-1];
            r_q[j]   <= r_q[j-1] | (Q_W'(w_ge) << (Q_W - j));
            r_d2[j]  <= r_d2[j-1];
            r_sat[j] <= r_sat[j-1];
            r_byp[j] <= r_byp[j-1];
            r_bv[j]  <= r_bv[j-1];
        end
    end

    assign o_res = r_byp[Q_W] ? r_bv[Q_W] : (r_sat[Q_W] ? FULL16 : PIX_W'(r_q[Q_W]));
endmodule

### design/temporal_mean_variance_denoise.sv
`timescale 1ns / 1ps
// Temporal mean / variance denoiser, one RGB-style 16-bit pixel per item.
// i_in  : cmd (add, subtract, output, clear), pixel_index, three samples.
// o_out : one item per output command, carrying out_index and three channels.
// i_cfg : register writes (reg_index, data), always ready; write only when idle.
// Per-channel running sums and square sums live in three single-port-read
// RAMs (one per channel, one word per pixel). An item reads its word the
// cycle it is accepted, modifies it and writes it back on the next cycle;
// a one-entry forward covers back-to-back items on the same pixel.
// Throughput: one item per clock while input ready is high. From input accept
// to the output item the path is the RAM read at the accepting edge, then 4
// statistics stages, 19 divider stages with one quotient bit in 16 of them,
// and the output queue write.
// Results drain through a 32-entry output queue. Ready stays high until 32
// output items are in flight or queued, so a stalled receiver throttles the
// input only after the queue budget is used up; no item is ever dropped.
// Reset: synchronous, active low. After reset a clearing pass zeroes the
// accumulator RAMs with input ready held low; register writes are accepted
// during that pass.
module temporal_mean_variance_denoise #(
    parameter int PIXELS     = 16384,
    parameter int MAX_FRAMES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tmvd_cfg_if.sink     i_cfg,
    tmvd_in_if.sink      i_in,
    tmvd_out_if.source   o_out
);
    import tmvd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int ENT_W  = SUM_W + SQ_W;
    localparam int NQ_W   = SQ_W + CNT_W;
    localparam int D_W    = (NQ_W > 2 * SUM_W) ? NQ_W : 2 * SUM_W;
    localparam int NUM_W  = D_W + GAIN_W;
    localparam int DEN_W  = 2 * CNT_W + GAIN_FRAC + PIX_W;
    localparam int CRED_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAMES);
    localparam logic [AW-1:0]    ADDR_LAST = AW'(PIXELS - 1);

    // configuration registers
    t_method           r_method;
    logic [GAIN_W-1:0] r_gain;
    logic [MT_W-1:0]   r_mthr;
    logic [VT_W-1:0]   r_vt [CH_N];
    logic [MASK_W-1:0] r_mask;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= MTH_SEL;
            r_gain   <= GAIN_W'(1) << GAIN_FRAC;
            r_mthr   <= '0;
            r_vt[0]  <= '0;
            r_vt[1]  <= '0;
            r_vt[2]  <= '0;
            r_mask   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_METHOD:   r_method <= t_method'(i_cfg.data[1:0]);
                REG_GAIN:     r_gain   <= i_cfg.data[GAIN_W-1:0];
                REG_MEAN_THR: r_mthr   <= i_cfg.data[MT_W-1:0];
                REG_VT1:      r_vt[0]  <= i_cfg.data[VT_W-1:0];
                REG_VT2:      r_vt[1]  <= i_cfg.data[VT_W-1:0];
                REG_VT3:      r_vt[2]  <= i_cfg.data[VT_W-1:0];
                REG_MASK:     r_mask   <= i_cfg.data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // input side
    logic             w_acc;
    logic             w_acc_out;
    logic             w_in_inside;
    logic [AW-1:0]    w_in_addr;
    logic [PIX_W-1:0] w_in_x [CH_N];
    logic             r_clr;
    logic [AW-1:0]    r_clr_addr;
    logic [CRED_W-1:0] r_cred;
    logic [CNT_W-1:0] r_cnt;

    assign w_in_x[0]   = i_in.chan_1;
    assign w_in_x[1]   = i_in.chan_2;
    assign w_in_x[2]   = i_in.chan_3;
    assign w_in_inside = 32'(i_in.pixel_index) < 32'(PIXELS);
    assign w_in_addr   = AW'(i_in.pixel_index);
    assign i_in.ready  = !r_clr && (r_cred < CRED_W'(FIFO_DEPTH));
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_acc_out   = w_acc && (t_cmd'(i_in.cmd) == CMD_OUT);

    // frame count, stepped by items at pixel 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_acc && (i_in.pixel_index == '0)) begin
            case (t_cmd'(i_in.cmd))
                CMD_ADD: if (r_cnt < CNT_MAX) r_cnt <= r_cnt + 1'b1;
                CMD_SUB: if (r_cnt != '0) r_cnt <= r_cnt - 1'b1;
                CMD_CLR: r_cnt <= '0;
                CMD_OUT: ;
            endcase
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            if (r_clr_addr == ADDR_LAST) begin
                r_clr <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // stage A: RAM data arrives, read-modify-write
    logic             r_a_vld;
    t_cmd             r_a_cmd;
    logic [AW-1:0]    r_a_addr;
    logic             r_a_in;
    logic             r_a_byp;
    logic [IDX_W-1:0] r_a_idx;
    logic [CNT_W-1:0] r_a_n;
    logic [PIX_W-1:0] r_a_x  [CH_N];
    logic [2*PIX_W-1:0] r_a_x2 [CH_N];
    logic             r_fwd_hit;
    logic [ENT_W-1:0] r_fwd_ent [CH_N];

    logic [ENT_W-1:0] w_rdata [CH_N];
    logic [ENT_W-1:0] w_cur   [CH_N];
    logic [ENT_W-1:0] w_new   [CH_N];
    logic [SUM_W-1:0] w_s     [CH_N];
    logic [SQ_W-1:0]  w_q     [CH_N];
    logic [SUM_W:0]   w_s_add [CH_N];
    logic [SQ_W:0]    w_q_add [CH_N];
    logic [SUM_W-1:0] w_s_new [CH_N];
    logic [SQ_W-1:0]  w_q_new [CH_N];
    logic             w_wr;
    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;

    assign w_wr        = r_a_vld && (r_a_cmd != CMD_OUT) && r_a_in;
    assign w_ram_we    = r_clr || w_wr;
    assign w_ram_waddr = r_clr ? r_clr_addr : r_a_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_a_vld   <= w_acc;
            r_fwd_hit <= w_acc && w_wr && (r_a_addr == w_in_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a_cmd  <= t_cmd'(i_in.cmd);
            r_a_addr <= w_in_addr;
            r_a_in   <= w_in_inside;
            r_a_idx  <= i_in.pixel_index;
            r_a_n    <= r_cnt;
            r_a_byp  <= !w_in_inside || (r_cnt == '0) || (r_method == MTH_PASS);
            for (int c = 0; c < CH_N; c++) begin
                r_a_x[c]  <= w_in_x[c];
                r_a_x2[c] <= (2*PIX_W)'(w_in_x[c]) * (2*PIX_W)'(w_in_x[c]);
            end
        end
        for (int c = 0; c < CH_N; c++) begin
            r_fwd_ent[c] <= w_new[c];
        end
    end

    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            w_cur[c]   = r_fwd_hit ? r_fwd_ent[c] : w_rdata[c];
            w_s[c]     = w_cur[c][SQ_W +: SUM_W];
            w_q[c]     = w_cur[c][SQ_W-1:0];
            w_s_add[c] = {1'b0, w_s[c]} + (SUM_W+1)'(r_a_x[c]);
            w_q_add[c] = {1'b0, w_q[c]} + (SQ_W+1)'(r_a_x2[c]);
            case (r_a_cmd)
                CMD_ADD: begin
                    w_s_new[c] = w_s_add[c][SUM_W] ? SUM_MAX : w_s_add[c][SUM_W-1:0];
                    w_q_new[c] = w_q_add[c][SQ_W] ? SQ_MAX : w_q_add[c][SQ_W-1:0];
                end
                CMD_SUB: begin
                    w_s_new[c] = (w_s[c] > SUM_W'(r_a_x[c]))
                                 ? (w_s[c] - SUM_W'(r_a_x[c])) : '0;
                    w_q_new[c] = (w_q[c] > SQ_W'(r_a_x2[c]))
                                 ? (w_q[c] - SQ_W'(r_a_x2[c])) : '0;
                end
                default: begin
                    w_s_new[c] = '0;
                    w_q_new[c] = '0;
                end
            endcase
            w_new[c] = {w_s_new[c], w_q_new[c]};
        end
    end

    // per-channel accumulator RAM, statistics and divider
    logic [PIX_W-1:0] w_res [CH_N];

    for (genvar c = 0; c < CH_N; c++) begin : g_ch
        t_chan_cfg        w_ccfg;
        logic [NUM_W-1:0] w_num;
        logic [DEN_W-1:0] w_den;
        logic             w_byp;
        logic [PIX_W-1:0] w_bval;

        assign w_ccfg = '{method: r_method, gain: r_gain, tm: r_mthr[c*PIX_W +: PIX_W],
                          vt: r_vt[c], masked: r_mask[c]};

        tmvd_ram #(
            .WIDTH (ENT_W),
            .DEPTH (PIXELS),
            .AW    (AW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_ram_we),
            .i_waddr (w_ram_waddr),
            .i_wdata (r_clr ? '0 : w_new[c]),
            .i_re    (w_acc),
            .i_raddr (w_in_addr),
            .o_rdata (w_rdata[c])
        );

        tmvd_stats #(
            .CNT_W (CNT_W),
            .NUM_W (NUM_W),
            .DEN_W (DEN_W)
        ) u_stats (
            .i_clk  (i_clk),
            .i_cfg  (w_ccfg),
            .i_byp  (r_a_byp),
            .i_x    (r_a_x[c]),
            .i_s    (w_s[c]),
            .i_q    (w_q[c]),
            .i_n    (r_a_n),
            .o_num  (w_num),
            .o_den  (w_den),
            .o_byp  (w_byp),
            .o_bval (w_bval)
        );

        tmvd_div #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W)
        ) u_div (
            .i_clk  (i_clk),
            .i_num  (w_num),
            .i_den  (w_den),
            .i_byp  (w_byp),
            .i_bval (w_bval),
            .o_res  (w_res[c])
        );
    end

    // valid and index travel alongside the datapath
    logic             r_vl [PIPE_LAT];
    logic [IDX_W-1:0] r_ix [PIPE_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                r_vl[i] <= 1'b0;
            end
        end else begin
            r_vl[0] <= r_a_vld && (r_a_cmd == CMD_OUT);
            for (int i = 1; i < PIPE_LAT; i++) begin
                r_vl[i] <= r_vl[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ix[0] <= r_a_idx;
        for (int i = 1; i < PIPE_LAT; i++) begin
            r_ix[i] <= r_ix[i-1];
        end
    end

    // output queue; credits bound what is in flight to its depth
    t_res              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW:0]  r_wp;
    logic [FIFO_AW:0]  r_rp;
    logic              w_push;
    logic              w_pop;
    t_res              w_head;
    logic [CRED_W-1:0] n_cred;

    assign w_push = r_vl[PIPE_LAT-1];
    assign w_pop  = o_out.valid && o_out.ready;
    assign n_cred = r_cred + CRED_W'(w_acc_out) - CRED_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cred <= '0;
        end else begin
            r_cred <= n_cred;
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp[FIFO_AW-1:0]] <= '{out_index: r_ix[PIPE_LAT-1], out_1: w_res[0],
                                           out_2: w_res[1], out_3: w_res[2]};
        end
    end

    assign w_head          = r_fifo[r_rp[FIFO_AW-1:0]];
    assign o_out.valid     = r_wp != r_rp;
    assign o_out.out_index = w_head.out_index;
    assign o_out.out_1     = w_head.out_1;
    assign o_out.out_2     = w_head.out_2;
    assign o_out.out_3     = w_head.out_3;
endmodule

### design/tmvd_chk.sv
`timescale 1ns / 1ps
module tmvd_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic [tmvd_pkg::IDX_W+3*tmvd_pkg::PIX_W-1:0] i_out_data
);
    import tmvd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_clear_busy: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_in_ready)
        else $error("input ready before clearing pass");
endmodule

bind temporal_mean_variance_denoise tmvd_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  ({o_out.out_index, o_out.out_1, o_out.out_2, o_out.out_3})
);
